### src/bsl_pkg.sv
// bsl_pkg: shared types, codes and constant tables for the source lexer
// no dependencies; imported by every module of the lexer
`timescale 1ns / 1ps

package bsl_pkg;

    localparam int LINE_BITS_DEF   = 16;
    localparam int COLUMN_BITS_DEF = 16;
    localparam int MAX_RES         = 3;
    localparam int NUM_KW          = 23;
    localparam int KW_BYTES        = 8;

    // input function codes
    localparam logic FUNC_CHAR = 1'b0;
    localparam logic FUNC_END  = 1'b1;

    // record kinds
    localparam logic [1:0] REC_TEXT  = 2'd0;
    localparam logic [1:0] REC_DONE  = 2'd1;
    localparam logic [1:0] REC_ERROR = 2'd2;

    // token kinds
    localparam logic [5:0] K_NUMBER   = 6'd0;
    localparam logic [5:0] K_STRING   = 6'd1;
    localparam logic [5:0] K_IDENT    = 6'd2;
    localparam logic [5:0] K_FIRST_KW = 6'd3;
    localparam logic [5:0] K_FIRST_OP = 6'd26;
    localparam logic [5:0] K_LT       = 6'd38;
    localparam logic [5:0] K_LE       = 6'd39;
    localparam logic [5:0] K_NE       = 6'd40;
    localparam logic [5:0] K_GT       = 6'd41;
    localparam logic [5:0] K_GE       = 6'd42;
    localparam logic [5:0] K_EOF      = 6'd43;

    typedef enum logic [3:0] {
        M_IDLE,
        M_NUMBER,
        M_STRING,
        M_ESCAPE,
        M_NAME,
        M_COMMENT,
        M_LESS,
        M_GREATER,
        M_HALT
    } t_mode;

    typedef struct packed {
        logic       func;
        logic [7:0] in_char;
    } t_in;

    typedef struct packed {
        logic [1:0]  rec_kind;
        logic [5:0]  token_kind;
        logic [7:0]  text_char;
        logic [15:0] line;
        logic [15:0] column;
        logic        last;
    } t_out;

    // all the records caused by one item
    typedef struct packed {
        logic [1:0]               count;
        t_out [MAX_RES-1:0]       recs;
    } t_grp;

    // keywords packed right-aligned, first character most significant
    localparam logic [8*KW_BYTES-1:0] KW_TEXT [NUM_KW] = '{
        "LET", "IF", "THEN", "ELSE", "FOR", "TO", "STEP", "NEXT", "WHILE",
        "WEND", "DO", "LOOP", "UNTIL", "SUB", "END", "FUNCTION", "RETURN",
        "PRINT", "INPUT", "READ", "DATA", "RESTORE", "DIM"
    };

    localparam logic [3:0] KW_LEN [NUM_KW] = '{
        4'd3, 4'd2, 4'd4, 4'd4, 4'd3, 4'd2, 4'd4, 4'd4, 4'd5,
        4'd4, 4'd2, 4'd4, 4'd5, 4'd3, 4'd3, 4'd8, 4'd6,
        4'd5, 4'd5, 4'd4, 4'd4, 4'd7, 4'd3
    };

    function automatic logic [5:0] name_kind(
        input logic [8*KW_BYTES-1:0] nbuf,
        input logic [3:0]            nlen
    );
        logic [5:0] kind;
        kind = K_IDENT;
        for (int k = 0; k < NUM_KW; k++) begin
            if (KW_LEN[k] == nlen && KW_TEXT[k] == nbuf) begin
                kind = K_FIRST_KW + 6'(k);
            end
        end
        return kind;
    endfunction

    function automatic t_out make_rec(
        input logic [1:0]  rk,
        input logic [5:0]  tk,
        input logic [7:0]  ch,
        input logic [15:0] ln,
        input logic [15:0] col
    );
        t_out r;
        r.rec_kind   = rk;
        r.token_kind = tk;
        r.text_char  = ch;
        r.line       = ln;
        r.column     = col;
        r.last       = 1'b0;
        return r;
    endfunction

endpackage

### src/bsl_core.sv
// bsl_core: scanner state and the single-pass step logic for one item
// depends on bsl_pkg; produces the record group for the result buffer
`timescale 1ns / 1ps

module bsl_core import bsl_pkg::*; #(
    parameter int LINE_BITS   = LINE_BITS_DEF,
    parameter int COLUMN_BITS = COLUMN_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_adv,
    input  t_in  i_item,
    output t_grp o_grp
);

    localparam logic [LINE_BITS-1:0]   LINE_ONE = LINE_BITS'(1);
    localparam logic [LINE_BITS-1:0]   LINE_MAX = {LINE_BITS{1'b1}};
    localparam logic [COLUMN_BITS-1:0] COL_ONE  = COLUMN_BITS'(1);
    localparam logic [COLUMN_BITS-1:0] COL_MAX  = {COLUMN_BITS{1'b1}};

    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_APOS   = 8'h27;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_POINT  = 8'h2E;
    localparam logic [7:0] CH_LESS   = 8'h3C;
    localparam logic [7:0] CH_GREAT  = 8'h3E;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    t_mode                    r_mode, n_mode;
    logic                     r_seen, n_seen;
    logic [8*KW_BYTES-1:0]    r_name, n_name;
    logic [3:0]               r_len, n_len;
    logic [LINE_BITS-1:0]     r_line, n_line;
    logic [COLUMN_BITS-1:0]   r_col, n_col;
    logic [COLUMN_BITS-1:0]   r_tsc, n_tsc;

    logic                   is_end;
    logic [7:0]             c;
    logic                   c_digit, c_alpha, c_word, c_space;
    logic                   op_hit;
    logic [5:0]             op_kind;
    logic                   num_cont, name_cont, rel_match;
    logic [5:0]             rel_kind;
    logic                   do_close, do_idle;
    logic [COLUMN_BITS-1:0] col_inc;
    logic [LINE_BITS-1:0]   line_inc;
    logic [5:0]             kw_kind;
    logic [7:0]             esc_map;
    logic [15:0]            line_o, tsc_o, col_o;
    t_out [MAX_RES-1:0]     recs;
    logic [1:0]             cnt;

    assign is_end  = (i_item.func == FUNC_END);
    assign c       = i_item.in_char;
    assign c_digit = (c >= "0") && (c <= "9");
    assign c_alpha = ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
    assign c_word  = c_alpha || c_digit || (c == CH_UNDER);
    assign c_space = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));

    always_comb begin
        op_hit  = 1'b1;
        op_kind = K_FIRST_OP;
        case (c)
            "+":     op_kind = K_FIRST_OP;
            "-":     op_kind = K_FIRST_OP + 6'd1;
            "*":     op_kind = K_FIRST_OP + 6'd2;
            "/":     op_kind = K_FIRST_OP + 6'd3;
            "%":     op_kind = K_FIRST_OP + 6'd4;
            "^":     op_kind = K_FIRST_OP + 6'd5;
            "(":     op_kind = K_FIRST_OP + 6'd6;
            ")":     op_kind = K_FIRST_OP + 6'd7;
            ",":     op_kind = K_FIRST_OP + 6'd8;
            ";":     op_kind = K_FIRST_OP + 6'd9;
            ":":     op_kind = K_FIRST_OP + 6'd10;
            "=":     op_kind = K_FIRST_OP + 6'd11;
            default: op_hit  = 1'b0;
        endcase
    end

    always_comb begin
        case (c)
            "n":       esc_map = CH_LF;
            "t":       esc_map = CH_TAB;
            "r":       esc_map = CH_CR;
            CH_QUOTE:  esc_map = CH_QUOTE;
            CH_BSLASH: esc_map = CH_BSLASH;
            default:   esc_map = 8'h00;
        endcase
    end

    assign num_cont  = (r_mode == M_NUMBER) && (c_digit || ((c == CH_POINT) && !r_seen));
    assign name_cont = (r_mode == M_NAME) && c_word;
    assign rel_match = ((r_mode == M_LESS) || (r_mode == M_GREATER)) &&
                       ((c == CH_EQUAL) || ((c == CH_GREAT) && (r_mode == M_LESS)));
    assign rel_kind  = (r_mode == M_GREATER) ? K_GE : ((c == CH_EQUAL) ? K_LE : K_NE);

    assign col_inc  = (r_col == COL_MAX) ? r_col : r_col + COL_ONE;
    assign line_inc = (r_line == LINE_MAX) ? r_line : r_line + LINE_ONE;
    assign kw_kind  = (r_len > 4'd8) ? K_IDENT : name_kind(r_name, r_len);

    assign line_o = 16'(r_line);
    assign tsc_o  = 16'(r_tsc);
    assign col_o  = 16'(r_col);

    // which parts of the step apply: closing an open token, scanning from idle
    always_comb begin
        do_close = 1'b0;
        do_idle  = 1'b0;
        if (is_end) begin
            do_close = (r_mode != M_HALT);
        end else begin
            case (r_mode)
                M_IDLE:    do_idle = 1'b1;
                M_COMMENT: do_idle = (c == CH_LF);
                M_NUMBER: begin
                    do_close = !num_cont;
                    do_idle  = !num_cont;
                end
                M_NAME: begin
                    do_close = !name_cont;
                    do_idle  = !name_cont;
                end
                M_LESS, M_GREATER: begin
                    do_close = !rel_match;
                    do_idle  = !rel_match;
                end
                M_STRING, M_ESCAPE, M_HALT: ;
                default:   do_idle = 1'b1;
            endcase
        end
    end

    // next state
    always_comb begin
        n_mode = r_mode;
        n_seen = r_seen;
        n_name = r_name;
        n_len  = r_len;
        n_line = r_line;
        n_col  = r_col;
        n_tsc  = r_tsc;
        if (is_end) begin
            n_mode = M_IDLE;
            n_seen = 1'b0;
            n_name = '0;
            n_len  = '0;
            n_line = LINE_ONE;
            n_col  = COL_ONE;
            n_tsc  = COL_ONE;
        end else begin
            case (r_mode)
                M_ESCAPE: begin
                    n_col  = col_inc;
                    n_mode = M_STRING;
                end
                M_STRING: begin
                    n_col = col_inc;
                    if (c == CH_QUOTE) begin
                        n_mode = M_IDLE;
                    end else if (c == CH_BSLASH) begin
                        n_mode = M_ESCAPE;
                    end
                end
                M_NUMBER: begin
                    if (num_cont) begin
                        if (c == CH_POINT) begin
                            n_seen = 1'b1;
                        end
                        n_col = col_inc;
                    end
                end
                M_NAME: begin
                    if (name_cont) begin
                        if (r_len < 4'd8) begin
                            n_name = {r_name[8*KW_BYTES-9:0], c};
                            n_len  = r_len + 4'd1;
                        end else begin
                            n_len = 4'd9;
                        end
                        n_col = col_inc;
                    end
                end
                M_LESS, M_GREATER: begin
                    if (rel_match) begin
                        n_mode = M_IDLE;
                        n_col  = col_inc;
                    end
                end
                default: ;
            endcase
            if (do_idle) begin
                n_mode = M_IDLE;
                if (c_space) begin
                    if (c == CH_LF) begin
                        n_line = line_inc;
                        n_col  = COL_ONE;
                    end else begin
                        n_col = col_inc;
                    end
                end else if (c == CH_APOS) begin
                    n_mode = M_COMMENT;
                end else if (c_digit || (c == CH_POINT)) begin
                    n_tsc  = r_col;
                    n_mode = M_NUMBER;
                    n_seen = (c == CH_POINT);
                    n_col  = col_inc;
                end else if (c == CH_QUOTE) begin
                    n_tsc  = r_col;
                    n_mode = M_STRING;
                    n_col  = col_inc;
                end else if (c_alpha || (c == CH_UNDER)) begin
                    n_tsc  = r_col;
                    n_mode = M_NAME;
                    n_name = (8*KW_BYTES)'(c);
                    n_len  = 4'd1;
                    n_col  = col_inc;
                end else if (c == CH_LESS) begin
                    n_tsc  = r_col;
                    n_mode = M_LESS;
                    n_col  = col_inc;
                end else if (c == CH_GREAT) begin
                    n_tsc  = r_col;
                    n_mode = M_GREATER;
                    n_col  = col_inc;
                end else if (op_hit) begin
                    n_tsc = r_col;
                    n_col = col_inc;
                end else begin
                    n_mode = M_HALT;
                end
            end
        end
    end

    // result records, appended in order
    always_comb begin
        recs = '0;
        cnt  = 2'd0;
        if (do_close) begin
            case (r_mode)
                M_NUMBER: begin
                    recs[cnt] = make_rec(REC_DONE, K_NUMBER, 8'h00, line_o, tsc_o);
                    cnt = cnt + 2'd1;
                end
                M_NAME: begin
                    recs[cnt] = make_rec(REC_DONE, kw_kind, 8'h00, line_o, tsc_o);
                    cnt = cnt + 2'd1;
                end
                M_ESCAPE: begin
                    recs[cnt] = make_rec(REC_TEXT, K_NUMBER, CH_BSLASH, line_o, tsc_o);
                    cnt = cnt + 2'd1;
                    recs[cnt] = make_rec(REC_DONE, K_STRING, 8'h00, line_o, tsc_o);
                    cnt = cnt + 2'd1;
                end
                M_STRING: begin
                    recs[cnt] = make_rec(REC_DONE, K_STRING, 8'h00, line_o, tsc_o);
                    cnt = cnt + 2'd1;
                end
                M_LESS: begin
                    recs[cnt] = make_rec(REC_DONE, K_LT, 8'h00, line_o, tsc_o);
                    cnt = cnt + 2'd1;
                end
                M_GREATER: begin
                    recs[cnt] = make_rec(REC_DONE, K_GT, 8'h00, line_o, tsc_o);
                    cnt = cnt + 2'd1;
                end
                default: ;
            endcase
        end
        if (is_end) begin
            if (r_mode != M_HALT) begin
                recs[cnt] = make_rec(REC_DONE, K_EOF, 8'h00, line_o, col_o);
                cnt = cnt + 2'd1;
            end
        end else begin
            case (r_mode)
                M_ESCAPE: begin
                    if (esc_map != 8'h00) begin
                        recs[cnt] = make_rec(REC_TEXT, K_NUMBER, esc_map, line_o, tsc_o);
                        cnt = cnt + 2'd1;
                    end else begin
                        recs[cnt] = make_rec(REC_TEXT, K_NUMBER, CH_BSLASH, line_o, tsc_o);
                        cnt = cnt + 2'd1;
                        recs[cnt] = make_rec(REC_TEXT, K_NUMBER, c, line_o, tsc_o);
                        cnt = cnt + 2'd1;
                    end
                end
                M_STRING: begin
                    if (c == CH_QUOTE) begin
                        recs[cnt] = make_rec(REC_DONE, K_STRING, 8'h00, line_o, tsc_o);
                        cnt = cnt + 2'd1;
                    end else if (c != CH_BSLASH) begin
                        recs[cnt] = make_rec(REC_TEXT, K_NUMBER, c, line_o, tsc_o);
                        cnt = cnt + 2'd1;
                    end
                end
                M_NUMBER, M_NAME: begin
                    if (num_cont || name_cont) begin
                        recs[cnt] = make_rec(REC_TEXT, K_NUMBER, c, line_o, tsc_o);
                        cnt = cnt + 2'd1;
                    end
                end
                M_LESS, M_GREATER: begin
                    if (rel_match) begin
                        recs[cnt] = make_rec(REC_TEXT, K_NUMBER, c, line_o, tsc_o);
                        cnt = cnt + 2'd1;
                        recs[cnt] = make_rec(REC_DONE, rel_kind, 8'h00, line_o, tsc_o);
                        cnt = cnt + 2'd1;
                    end
                end
                default: ;
            endcase
            if (do_idle) begin
                if (c_digit || c_alpha || (c == CH_POINT) || (c == CH_UNDER) ||
                    (c == CH_LESS) || (c == CH_GREAT)) begin
                    recs[cnt] = make_rec(REC_TEXT, K_NUMBER, c, line_o, col_o);
                    cnt = cnt + 2'd1;
                end else if (op_hit) begin
                    recs[cnt] = make_rec(REC_TEXT, K_NUMBER, c, line_o, col_o);
                    cnt = cnt + 2'd1;
                    recs[cnt] = make_rec(REC_DONE, op_kind, 8'h00, line_o, col_o);
                    cnt = cnt + 2'd1;
                end else if (!c_space && (c != CH_APOS) && (c != CH_QUOTE)) begin
                    recs[cnt] = make_rec(REC_ERROR, K_NUMBER, c, line_o, col_o);
                    cnt = cnt + 2'd1;
                end
            end
        end
        if (cnt != 2'd0) begin
            recs[cnt - 2'd1].last = 1'b1;
        end
    end

    assign o_grp.count = cnt;
    assign o_grp.recs  = recs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_seen <= 1'b0;
            r_name <= '0;
            r_len  <= '0;
            r_line <= LINE_ONE;
            r_col  <= COL_ONE;
            r_tsc  <= COL_ONE;
        end else if (i_adv) begin
            r_mode <= n_mode;
            r_seen <= n_seen;
            r_name <= n_name;
            r_len  <= n_len;
            r_line <= n_line;
            r_col  <= n_col;
            r_tsc  <= n_tsc;
        end
    end

endmodule

### src/bsl_obuf.sv
// bsl_obuf: result register holding one item's record group, drained one record a cycle while i_ready is high
// depends on bsl_pkg
`timescale 1ns / 1ps

module bsl_obuf import bsl_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_load,
    input  t_grp i_grp,
    output logic o_can_load,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_data
);

    logic       r_full;
    logic [1:0] r_idx;
    t_grp       r_grp;
    logic       at_end;

    assign at_end     = (r_idx == (r_grp.count - 2'd1));
    assign o_can_load = !r_full || (i_ready && at_end);
    assign o_valid    = r_full;
    assign o_data     = r_grp.recs[r_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
            r_idx  <= 2'd0;
        end else if (i_load) begin
            // an item with no records leaves the buffer empty
            r_full <= (i_grp.count != 2'd0);
            r_idx  <= 2'd0;
        end else if (r_full && i_ready) begin
            if (at_end) begin
                r_full <= 1'b0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_grp <= i_grp;
        end
    end

endmodule

### src/basic_source_lexer.sv
// basic_source_lexer: an accepted item waits in the input register; its records then pass
// through the result register, from which the first record is valid on the output port
// throughput one item per cycle while each item gives at most one record and output is ready;
// an item giving more records holds the result register until all leave by its single read port
// reset is synchronous, active low: line and column return to 1, scanner to idle
// end of input also returns the scanner to its reset state; no clearing pass needed
// depends on bsl_pkg, bsl_core, bsl_obuf
`timescale 1ns / 1ps

module basic_source_lexer import bsl_pkg::*; #(
    parameter int LINE_BITS   = LINE_BITS_DEF,
    parameter int COLUMN_BITS = COLUMN_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    logic r_in_valid;
    t_in  r_in;
    logic can_load;
    logic adv;
    t_grp grp;

    // item moves from the input register into the result register
    assign adv        = r_in_valid && can_load;
    assign o_in_ready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
    end

    bsl_core #(
        .LINE_BITS   (LINE_BITS),
        .COLUMN_BITS (COLUMN_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_item  (r_in),
        .o_grp   (grp)
    );

    bsl_obuf u_obuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (adv),
        .i_grp      (grp),
        .o_can_load (can_load),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_data     (o_out_data)
    );

`ifndef NO_ASSERTIONS
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && (grp.count != 2'd0)) |=> o_out_valid)
        else $error("record group loaded but no output valid");

    a_error_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.rec_kind == REC_ERROR)) |-> o_out_data.last)
        else $error("error record not final for its item");

    a_text_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.rec_kind != REC_DONE)) |->
        (o_out_data.token_kind == K_NUMBER))
        else $error("text or error record carries a token kind");

    a_no_stall_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !o_out_valid) |-> o_in_ready)
        else $error("input held while result register empty");
`endif

endmodule

### tb/lexer_checker.sv
// lexer_checker: watches both channels of basic_source_lexer, predicts the records of every
// accepted item and compares the records that come out, in order; depends on bsl_pkg
`timescale 1ns / 1ps

module lexer_checker import bsl_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_ready,
    input  t_in  i_in_data,
    input  logic i_out_valid,
    input  logic i_out_ready,
    input  t_out i_out_data,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_records_seen
);

    localparam logic [15:0] COUNT_MAX = 16'hffff;
    localparam logic [5:0]  NO_KIND   = 6'd0;
    localparam logic [7:0]  NO_CHAR   = 8'h00;
    localparam logic [7:0]  LF        = 8'h0a;

    string kw_names [23] = '{
        "LET", "IF", "THEN", "ELSE", "FOR", "TO", "STEP", "NEXT", "WHILE",
        "WEND", "DO", "LOOP", "UNTIL", "SUB", "END", "FUNCTION", "RETURN",
        "PRINT", "INPUT", "READ", "DATA", "RESTORE", "DIM"
    };

    t_mode       scan_state;
    bit          point_seen;
    logic [7:0]  name_chars [8];
    logic [3:0]  name_len;
    logic [15:0] cur_line;
    logic [15:0] cur_col;
    logic [15:0] tok_col;
    t_out        expected_recs [$];

    function automatic bit is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_alpha(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic bit is_blank(input logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    // position in the single-character operator group, -1 when none
    function automatic int op_offset(input logic [7:0] c);
        case (c)
            "+": return 0;
            "-": return 1;
            "*": return 2;
            "/": return 3;
            "%": return 4;
            "^": return 5;
            "(": return 6;
            ")": return 7;
            ",": return 8;
            ";": return 9;
            ":": return 10;
            "=": return 11;
            default: return -1;
        endcase
    endfunction

    function automatic logic [5:0] name_token();
        bit same;
        if (name_len > 4'd8) return K_IDENT;
        for (int k = 0; k < 23; k++) begin
            if (kw_names[k].len() == int'(name_len)) begin
                same = 1'b1;
                for (int i = 0; i < int'(name_len); i++) begin
                    if (kw_names[k].getc(i) != name_chars[i]) same = 1'b0;
                end
                if (same) return K_FIRST_KW + 6'(k);
            end
        end
        return K_IDENT;
    endfunction

    task automatic add_rec(input logic [1:0] rk, input logic [5:0] tk, input logic [7:0] ch,
                           input logic [15:0] col);
        t_out r;
        r.rec_kind   = rk;
        r.token_kind = tk;
        r.text_char  = ch;
        r.line       = cur_line;
        r.column     = col;
        r.last       = 1'b0;
        expected_recs.push_back(r);
    endtask

    task automatic step_col();
        if (cur_col != COUNT_MAX) cur_col = cur_col + 16'd1;
    endtask

    task automatic end_token(input logic [5:0] kind);
        add_rec(REC_DONE, kind, NO_CHAR, tok_col);
        scan_state = M_IDLE;
    endtask

    task automatic open_token(input t_mode m);
        tok_col    = cur_col;
        scan_state = m;
    endtask

    // a token cut short by the current byte or by end of input
    task automatic close_token();
        case (scan_state)
            M_NUMBER:  end_token(K_NUMBER);
            M_NAME:    end_token(name_token());
            M_ESCAPE: begin
                add_rec(REC_TEXT, NO_KIND, "\\", tok_col);
                end_token(K_STRING);
            end
            M_STRING:  end_token(K_STRING);
            M_LESS:    end_token(K_LT);
            M_GREATER: end_token(K_GT);
            default:   scan_state = M_IDLE;
        endcase
    endtask

    task automatic clear_scanner();
        scan_state = M_IDLE;
        point_seen = 1'b0;
        name_len   = 4'd0;
        foreach (name_chars[i]) name_chars[i] = 8'h00;
        cur_line   = 16'd1;
        cur_col    = 16'd1;
        tok_col    = 16'd1;
    endtask

    task automatic idle_char(input logic [7:0] c);
        int op;
        op = op_offset(c);
        if (is_blank(c)) begin
            if (c == LF) begin
                if (cur_line != COUNT_MAX) cur_line = cur_line + 16'd1;
                cur_col = 16'd1;
            end else begin
                step_col();
            end
        end else if (c == "'") begin
            scan_state = M_COMMENT;
        end else if (is_digit(c) || c == ".") begin
            open_token(M_NUMBER);
            point_seen = (c == ".");
            add_rec(REC_TEXT, NO_KIND, c, tok_col);
            step_col();
        end else if (c == "\"") begin
            open_token(M_STRING);
            step_col();
        end else if (is_alpha(c) || c == "_") begin
            open_token(M_NAME);
            name_chars[0] = c;
            name_len = 4'd1;
            add_rec(REC_TEXT, NO_KIND, c, tok_col);
            step_col();
        end else if (c == "<" || c == ">") begin
            if (c == "<") open_token(M_LESS);
            else open_token(M_GREATER);
            add_rec(REC_TEXT, NO_KIND, c, tok_col);
            step_col();
        end else if (op >= 0) begin
            tok_col = cur_col;
            add_rec(REC_TEXT, NO_KIND, c, tok_col);
            end_token(K_FIRST_OP + 6'(op));
            step_col();
        end else begin
            add_rec(REC_ERROR, NO_KIND, c, cur_col);
            scan_state = M_HALT;
        end
    endtask

    task automatic scan_char(input logic [7:0] c);
        logic [7:0] mapped;
        bit fresh;
        fresh = 1'b0;
        case (scan_state)
            M_HALT: ;
            M_COMMENT: begin
                if (c == LF) begin
                    scan_state = M_IDLE;
                    fresh = 1'b1;
                end
            end
            M_ESCAPE: begin
                case (c)
                    "n":        mapped = LF;
                    "t":        mapped = 8'h09;
                    "r":        mapped = 8'h0d;
                    "\"", "\\": mapped = c;
                    default:    mapped = NO_CHAR;
                endcase
                if (mapped != NO_CHAR) begin
                    add_rec(REC_TEXT, NO_KIND, mapped, tok_col);
                end else begin
                    add_rec(REC_TEXT, NO_KIND, "\\", tok_col);
                    add_rec(REC_TEXT, NO_KIND, c, tok_col);
                end
                step_col();
                scan_state = M_STRING;
            end
            M_STRING: begin
                // a line feed inside a string only moves the column
                if (c == "\"") end_token(K_STRING);
                else if (c == "\\") scan_state = M_ESCAPE;
                else add_rec(REC_TEXT, NO_KIND, c, tok_col);
                step_col();
            end
            M_NUMBER: begin
                if (is_digit(c) || (c == "." && !point_seen)) begin
                    if (c == ".") point_seen = 1'b1;
                    add_rec(REC_TEXT, NO_KIND, c, tok_col);
                    step_col();
                end else begin
                    close_token();
                    fresh = 1'b1;
                end
            end
            M_NAME: begin
                if (is_alpha(c) || is_digit(c) || c == "_") begin
                    if (name_len < 4'd8) begin
                        name_chars[name_len] = c;
                        name_len = name_len + 4'd1;
                    end else begin
                        name_len = 4'd9;
                    end
                    add_rec(REC_TEXT, NO_KIND, c, tok_col);
                    step_col();
                end else begin
                    close_token();
                    fresh = 1'b1;
                end
            end
            M_LESS, M_GREATER: begin
                if (c == "=" || (c == ">" && scan_state == M_LESS)) begin
                    add_rec(REC_TEXT, NO_KIND, c, tok_col);
                    if (scan_state == M_GREATER) end_token(K_GE);
                    else if (c == "=") end_token(K_LE);
                    else end_token(K_NE);
                    step_col();
                end else begin
                    close_token();
                    fresh = 1'b1;
                end
            end
            default: begin
                scan_state = M_IDLE;
                fresh = 1'b1;
            end
        endcase
        if (fresh) idle_char(c);
    endtask

    task automatic predict_item(input t_in it);
        int prior;
        prior = expected_recs.size();
        if (it.func == FUNC_END) begin
            // a halted scanner just starts over without a record
            if (scan_state != M_HALT) begin
                close_token();
                add_rec(REC_DONE, K_EOF, NO_CHAR, cur_col);
            end
            clear_scanner();
        end else begin
            scan_char(it.in_char);
        end
        if (expected_recs.size() > prior) expected_recs[expected_recs.size() - 1].last = 1'b1;
    endtask

    task automatic check_record(input t_out got);
        t_out want;
        bit bad;
        string what;
        want = '0;
        what = "record mismatch";
        if (expected_recs.size() == 0) begin
            bad = 1'b1;
            what = "record with nothing expected";
        end else begin
            want = expected_recs.pop_front();
            bad = got.rec_kind !== want.rec_kind || got.token_kind !== want.token_kind
                || got.text_char !== want.text_char || got.line !== want.line
                || got.column !== want.column || got.last !== want.last;
        end
        if (bad) begin
            o_fail_count++;
            if (o_fail_count <= 10) begin
                $display("%0t: %s: expected rec %0d kind %0d char %02h line %0d col %0d last %0b,",
                         $time, what, want.rec_kind, want.token_kind, want.text_char,
                         want.line, want.column, want.last,
                         " got rec %0d kind %0d char %02h line %0d col %0d last %0b",
                         got.rec_kind, got.token_kind, got.text_char, got.line, got.column,
                         got.last);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_scanner();
            expected_recs.delete();
            o_fail_count   = 0;
            o_records_seen = 0;
        end else begin
            if (i_in_valid && i_in_ready) predict_item(i_in_data);
            if (i_out_valid && i_out_ready) begin
                o_records_seen++;
                check_record(i_out_data);
            end
        end
        o_pending = expected_recs.size();
    end

endmodule

### tb/testbench.sv
// testbench: feeds source bytes and end-of-input items to basic_source_lexer with random idling
// on both channels; depends on bsl_pkg, basic_source_lexer and lexer_checker
`timescale 1ns / 1ps

module testbench;
    import bsl_pkg::*;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    t_in  in_data   = '0;
    logic out_ready = 1'b0;
    logic in_ready;
    logic out_valid;
    t_out out_data;
    int   fail_count;
    int   pending;
    int   records_seen;

    bit steady       = 1'b0;   // no new gaps on either side while set
    bit counting     = 1'b1;
    int useful_items = 0;
    int streams      = 0;
    int stall        = 0;

    string kw_texts [23] = '{
        "LET", "IF", "THEN", "ELSE", "FOR", "TO", "STEP", "NEXT", "WHILE",
        "WEND", "DO", "LOOP", "UNTIL", "SUB", "END", "FUNCTION", "RETURN",
        "PRINT", "INPUT", "READ", "DATA", "RESTORE", "DIM"
    };
    string op_texts [17] = '{
        "+", "-", "*", "/", "%", "^", "(", ")", ",", ";", ":", "=",
        "<", "<=", "<>", ">", ">="
    };

    basic_source_lexer dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    lexer_checker token_check (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_in_data      (in_data),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_out_data     (out_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_records_seen (records_seen)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(25, 60);
    endfunction

    function automatic int sender_gap();
        if (steady || $urandom_range(0, 1) == 0) return 0;
        return idle_len();
    endfunction

    function automatic logic [7:0] rand_alpha();
        int r;
        r = $urandom_range(0, 51);
        return (r < 26) ? 8'("A" + r) : 8'("a" + r - 26);
    endfunction

    function automatic logic [7:0] rand_digit();
        return 8'("0" + $urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] rand_name_char();
        int r;
        r = $urandom_range(0, 63);
        if (r < 52) return rand_alpha();
        if (r < 62) return rand_digit();
        return "_";
    endfunction

    always @(posedge clk) begin
        if (stall != 0) begin
            out_ready <= 1'b0;
            stall <= stall - 1;
        end else if (!steady && $urandom_range(0, 4) == 0) begin
            out_ready <= 1'b0;
            stall <= idle_len() - 1;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // valid stays high from one item to the next unless a gap is wanted
    task automatic send_item(input logic f, input logic [7:0] c);
        int gap;
        gap = sender_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= t_in'({f, c});
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (counting) useful_items++;
    endtask

    task automatic send_char(input logic [7:0] c);
        send_item(FUNC_CHAR, c);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s.getc(i));
    endtask

    task automatic send_end();
        send_item(FUNC_END, 8'($urandom_range(0, 255)));
        streams++;
    endtask

    task automatic hold_until_drained();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        @(posedge clk);
    endtask

    task automatic send_token();
        string kw;
        logic [7:0] c;
        int len;
        int pos;
        case ($urandom_range(0, 9))
            0, 1: begin
                kw = kw_texts[$urandom_range(0, 22)];
                // case flip: matching is case-sensitive
                if ($urandom_range(0, 5) == 0) begin
                    pos = $urandom_range(0, kw.len() - 1);
                    kw.putc(pos, kw.getc(pos) ^ 8'h20);
                end
                send_text(kw);
                if ($urandom_range(0, 5) == 0) send_char(rand_name_char());
            end
            2, 3: begin
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 6);
                send_char(($urandom_range(0, 7) == 0) ? 8'("_") : rand_alpha());
                repeat (len - 1) send_char(rand_name_char());
            end
            4: begin
                if ($urandom_range(0, 4) == 0) send_char(".");
                repeat ($urandom_range(1, 4)) send_char(rand_digit());
                if ($urandom_range(0, 2) == 0) begin
                    send_char(".");
                    repeat ($urandom_range(0, 3)) send_char(rand_digit());
                end
                if ($urandom_range(0, 5) == 0) begin
                    send_char(".");
                    send_char(rand_digit());
                end
            end
            5: begin
                send_char("\"");
                repeat ($urandom_range(0, 6)) begin
                    pos = $urandom_range(0, 9);
                    if (pos < 2) begin
                        send_char("\\");
                        case ($urandom_range(0, 6))
                            0: c = "n";
                            1: c = "t";
                            2: c = "r";
                            3: c = "\"";
                            4: c = "\\";
                            default: c = 8'($urandom_range(0, 255));
                        endcase
                        send_char(c);
                    end else if (pos == 2) begin
                        send_char("\n");
                    end else begin
                        c = 8'($urandom_range(32, 126));
                        if (c == "\"" || c == "\\") c = "x";
                        send_char(c);
                    end
                end
                if ($urandom_range(0, 9) != 0) send_char("\"");
            end
            6, 7: send_text(op_texts[$urandom_range(0, 16)]);
            8: send_char("\n");
            default: begin
                send_char("'");
                counting = 1'b0;
                repeat ($urandom_range(0, 5)) begin
                    c = 8'($urandom_range(0, 255));
                    if (c == "\n") c = "!";
                    send_char(c);
                end
                counting = 1'b1;
                send_char("\n");
            end
        endcase
        case ($urandom_range(0, 9))
            0, 1, 2: send_char(" ");
            3:       send_char("\t");
            4:       send_char(8'($urandom_range(11, 13)));
            default: ;
        endcase
    endtask

    task automatic send_stream();
        int n;
        n = $urandom_range(4, 20);
        for (int t = 0; t < n; t++) begin
            if ($urandom_range(0, 24) == 0) begin
                send_char(($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255)));
                // whatever follows a bad byte is dropped by the halted scanner
                counting = 1'b0;
                repeat ($urandom_range(0, 3)) send_char(8'($urandom_range(0, 255)));
                counting = 1'b1;
                break;
            end
            send_token();
        end
        send_end();
    endtask

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // escapes, second point, long name, operator pair, comment, halt, open escape
        send_text("\"\\q\\n\"");
        send_text(".5.");
        send_text("FUNCTIONS<=");
        send_char("'");
        send_char(8'hff);
        send_char("\n");
        send_char(8'h80);
        send_char(8'h00);
        send_end();
        send_text("\"\\");
        send_end();

        while (useful_items < 180) begin
            steady = ($urandom_range(0, 3) == 0);
            send_stream();
            if (streams == 3) hold_until_drained();
        end

        in_valid <= 1'b0;
        for (int w = 0; w < 20000 && pending != 0; w++) @(negedge clk);
        repeat (20) @(posedge clk);
        @(negedge clk);
        $display("%0d scanned items in %0d streams", useful_items, streams);
        $display("%0d records compared over keywords, names, numbers, strings, operators, halts",
                 records_seen);
        if (pending != 0) $display("%0d expected records never arrived", pending);
        if (fail_count == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #25_000_000;
        $display("run timed out");
        $display("TEST FAILED");
        $finish;
    end

endmodule
